/* design/knt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knt_pkg
// Shared types and constants for the Keith number test unit.
// ----------------------------------------------------------------------------
package knt_pkg;

	localparam int DEF_MAX_DIGITS = 8;
	localparam int CAND_W         = 27;
	localparam int TERM_W         = 30;
	localparam int CNT_W          = 4;
	localparam int STEP_W         = 13;

	// floor(n / 10) = (n * RECIP) >> RECIP_SHIFT, exact for n < 2^30
	localparam int RECIP_SHIFT = 31;
	localparam int PROD_W      = CAND_W + RECIP_SHIFT + 1;
	localparam logic [PROD_W-1:0] RECIP = PROD_W'(28'd214748365);

	localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXTRACT,
		ST_RUN
	} knt_state_t;

endpackage

/* design/knt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knt_cand_if / knt_res_if
// Valid/ready channels for candidates and test results.
// ----------------------------------------------------------------------------
interface knt_cand_if import knt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CAND_W-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink   (input valid, input candidate, output ready);
endinterface

interface knt_res_if import knt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             is_keith;
	logic [CNT_W-1:0] digit_count;

	modport source (output valid, output is_keith, output digit_count, input ready);
	modport sink   (input valid, input is_keith, input digit_count, output ready);
endinterface

/* design/keith_number_test_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keith_number_test_unit
// Decides whether a candidate is a Keith number: splits it into decimal
// digits, then runs the digit-sum recurrence until a term reaches or passes it or the step limit is hit.
//
//  channel  dir  payload                    transaction
//  cand     in   candidate[26:0]            valid & ready
//  result   out  is_keith, digit_count[3:0] valid & ready
//
// Digits: one per cycle through the reciprocal divide-by-10 multiplier; then
//   one recurrence step per cycle through the add/saturate unit. Zero or too
//   many digits skip the recurrence.
// cand.ready is high only in idle; one candidate in flight.
// A finished result waits in the output register; the next candidate is taken
//   meanwhile, and its own finish holds until the register is free.
// Reset: asynchronous, clears control state and the result valid.
// ----------------------------------------------------------------------------
module keith_number_test_unit import knt_pkg::*; #(
	parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
	input  logic             clk,
	input  logic             arst_n,
	knt_cand_if.sink         cand,
	knt_res_if.source        result
);

	localparam int PW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	knt_state_t state_q, state_d;

	logic [CAND_W-1:0] cand_q;
	logic [CAND_W-1:0] rest_q;
	logic [CNT_W-1:0]  k_q;
	logic [TERM_W-1:0] term_q [MAX_DIGITS];
	logic [TERM_W-1:0] sum_q;
	logic [TERM_W-1:0] last_q;
	logic [PW-1:0]     pos_q;
	logic [STEP_W-1:0] steps_q;

	logic              res_valid_q;
	logic              res_keith_q;
	logic [CNT_W-1:0]  res_count_q;

	logic              accept;
	logic              slot_free;
	logic              finish;
	logic              fin_keith;
	logic              run_go;

	logic [PROD_W-1:0] prod;
	logic [CAND_W-1:0] quo;
	logic [CAND_W-1:0] quo_x10;
	logic [CAND_W-1:0] rem;
	logic [3:0]        digit;

	logic [TERM_W-1:0] oldest;
	logic [TERM_W+1:0] nsum_w;
	logic [TERM_W-1:0] nsum;
	logic [PW:0]       pos_inc;

	assign accept     = cand.valid && cand.ready;
	assign cand.ready = (state_q == ST_IDLE);
	assign slot_free  = !res_valid_q || result.ready;

	// divide by 10
	assign prod    = PROD_W'(rest_q) * RECIP;
	assign quo     = prod[CAND_W+RECIP_SHIFT-1:RECIP_SHIFT];
	assign quo_x10 = {quo[CAND_W-4:0], 3'b000} + {quo[CAND_W-2:0], 1'b0};
	assign rem     = rest_q - quo_x10;
	assign digit   = rem[3:0];

	// recurrence step: new sum = 2*sum - oldest, saturated
	assign oldest  = term_q[pos_q];
	assign nsum_w  = {2'b00, sum_q} + {2'b00, sum_q} - {2'b00, oldest};
	assign nsum    = (nsum_w[TERM_W+1] || nsum_w[TERM_W]) ? TERM_MAX : nsum_w[TERM_W-1:0];
	assign pos_inc = {1'b0, pos_q} + 1'b1;

	assign run_go = (last_q < TERM_W'(cand_q)) && !steps_q[STEP_W-1];

	always_comb begin
		state_d   = state_q;
		finish    = 1'b0;
		fin_keith = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXTRACT;
				end
			end
			ST_EXTRACT: begin
				if (rest_q == '0) begin
					if (k_q == '0 || k_q > CNT_W'(MAX_DIGITS)) begin
						if (slot_free) begin
							finish  = 1'b1;
							state_d = ST_IDLE;
						end
					end else begin
						state_d = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (!run_go && slot_free) begin
					finish    = 1'b1;
					fin_keith = (last_q == TERM_W'(cand_q));
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			sum_q   <= '0;
			pos_q   <= '0;
			steps_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q     <= '0;
						sum_q   <= '0;
						pos_q   <= '0;
						steps_q <= '0;
					end
				end
				ST_EXTRACT: begin
					if (rest_q != '0) begin
						k_q   <= k_q + 1'b1;
						sum_q <= sum_q + TERM_W'(digit);
					end
				end
				ST_RUN: begin
					if (run_go) begin
						sum_q   <= nsum;
						steps_q <= steps_q + 1'b1;
						pos_q   <= (5'(pos_inc) >= 5'(k_q)) ? '0 : pos_inc[PW-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cand_q <= cand.candidate;
					rest_q <= cand.candidate;
				end
			end
			ST_EXTRACT: begin
				if (rest_q != '0) begin
					rest_q <= quo;
					if (k_q == '0) begin
						last_q <= TERM_W'(digit);
					end
					term_q[0] <= TERM_W'(digit);
					for (int i = 1; i < MAX_DIGITS; i++) begin
						term_q[i] <= term_q[i-1];
					end
				end
			end
			ST_RUN: begin
				if (run_go) begin
					term_q[pos_q] <= sum_q;
					last_q        <= sum_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (finish) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_keith_q <= fin_keith;
			res_count_q <= k_q;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.is_keith    = res_keith_q;
	assign result.digit_count = res_count_q;

	a_accept_extract: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXTRACT)
		else $error("accepted transaction did not start digit extraction");

	a_run_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> k_q != '0 && k_q <= CNT_W'(MAX_DIGITS))
		else $error("recurrence running with invalid digit count");

	a_run_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> 5'(pos_q) < 5'(k_q))
		else $error("window position beyond digit count");

	a_keith_count: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.is_keith |-> result.digit_count != '0 &&
			result.digit_count <= CNT_W'(MAX_DIGITS))
		else $error("Keith result with impossible digit count");

	a_finish_slot: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> slot_free)
		else $error("result register overwritten");

endmodule

/* bench/tb_keith_number_test_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keith_number_test_unit
// Self-checking bench for the Keith number test unit. A directed table of
// candidates (zero, single digits, edge widths, known Keith numbers, nine-digit
// values) is followed by random candidates over four flow-control phases.
// Every result transaction is compared field by field, in order, against the
// row's stored verdict or a local recurrence predictor.
// ----------------------------------------------------------------------------
module tb_keith_number_test_unit;
	import knt_pkg::*;

	localparam int MAX_DIGITS   = DEF_MAX_DIGITS;
	localparam int STEP_CAP     = 4096;
	localparam int RAND_PER_PH  = 275;
	localparam int TAIL_CYCLES  = 64;
	localparam int LIMIT_CYCLES = 2000000;
	localparam int MAX_SHOWN    = 10;
	localparam int N_KEITH      = 39;
	localparam int N_ROWS       = 25;

	typedef struct packed {
		logic             is_keith;
		logic [CNT_W-1:0] digit_count;
	} keith_verdict_t;

	typedef struct packed {
		logic [CAND_W-1:0] value;
		logic              typed;
		logic              is_keith;
		logic [CNT_W-1:0]  digit_count;
	} stim_row_t;

	localparam int unsigned KEITH_SET [N_KEITH] = '{
		14, 19, 28, 47, 61, 75, 197, 742, 1104, 1537, 2208, 2580, 3684,
		4788, 7385, 7647, 7909, 31331, 34285, 34348, 55604, 62662, 86935,
		93993, 120284, 129106, 147640, 156146, 174680, 183186, 298320,
		355419, 694280, 925993, 1084051, 7913837, 11436171, 33445755, 44121607
	};

	// typed rows carry their verdict; the rest go through the predictor
	localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{27'd0,         1'b1, 1'b0, 4'd0},
		'{27'd1,         1'b1, 1'b1, 4'd1},
		'{27'd5,         1'b1, 1'b1, 4'd1},
		'{27'd9,         1'b1, 1'b1, 4'd1},
		'{27'd10,        1'b1, 1'b0, 4'd2},
		'{27'd14,        1'b0, 1'b0, 4'd0},
		'{27'd15,        1'b0, 1'b0, 4'd0},
		'{27'd19,        1'b0, 1'b0, 4'd0},
		'{27'd99,        1'b0, 1'b0, 4'd0},
		'{27'd197,       1'b0, 1'b0, 4'd0},
		'{27'd742,       1'b0, 1'b0, 4'd0},
		'{27'd1000,      1'b0, 1'b0, 4'd0},
		'{27'd7909,      1'b0, 1'b0, 4'd0},
		'{27'd31331,     1'b0, 1'b0, 4'd0},
		'{27'd129106,    1'b0, 1'b0, 4'd0},
		'{27'd7913837,   1'b0, 1'b0, 4'd0},
		'{27'd10000000,  1'b0, 1'b0, 4'd0},
		'{27'd11436171,  1'b0, 1'b0, 4'd0},
		'{27'd33445755,  1'b0, 1'b0, 4'd0},
		'{27'd44121607,  1'b0, 1'b0, 4'd0},
		'{27'd44121608,  1'b0, 1'b0, 4'd0},
		'{27'd99999999,  1'b0, 1'b0, 4'd0},
		'{27'd100000000, 1'b1, 1'b0, 4'd9},
		'{27'd123456789, 1'b1, 1'b0, 4'd9},
		'{27'h7FFFFFF,   1'b1, 1'b0, 4'd9}
	};

	logic clk;
	logic arst_n;

	knt_cand_if cand_ch ();
	knt_res_if  res_ch ();

	keith_verdict_t pending_verdicts [$];
	int             mismatch_count;
	int             cycle_count;
	int             send_idle_pct;
	int             recv_stall_pct;

	keith_number_test_unit #(
		.MAX_DIGITS(MAX_DIGITS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (cand_ch.sink),
		.result (res_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic keith_verdict_t keith_predict(input logic [CAND_W-1:0] n);
		logic [3:0]        lsd [0:9];
		logic [TERM_W-1:0] ring [0:7];
		logic [TERM_W-1:0] total;
		logic [TERM_W-1:0] fresh;
		logic [TERM_W-1:0] last;
		logic [TERM_W:0]   nsum;
		int unsigned       rest;
		int unsigned       k;
		int unsigned       idx;
		int unsigned       pos;
		int unsigned       steps;
		keith_verdict_t    v;
		rest = n;
		k = 0;
		while (rest > 0 && k < 10) begin
			lsd[k] = 4'(rest % 10);
			rest = rest / 10;
			k++;
		end
		v.is_keith = 1'b0;
		v.digit_count = k[CNT_W-1:0];
		if (k == 0 || k > MAX_DIGITS)
			return v;
		total = '0;
		for (idx = 0; idx < k; idx++) begin
			ring[idx] = TERM_W'(lsd[k-1-idx]);
			total = total + TERM_W'(lsd[k-1-idx]);
		end
		last = TERM_W'(lsd[0]);
		pos = 0;
		steps = 0;
		while (last < TERM_W'(n) && steps < STEP_CAP) begin
			fresh = total;
			nsum = {1'b0, total} + {1'b0, fresh} - {1'b0, ring[pos]};
			total = (nsum > {1'b0, TERM_MAX}) ? TERM_MAX : nsum[TERM_W-1:0];
			ring[pos] = fresh;
			pos++;
			if (pos >= k)
				pos = 0;
			last = fresh;
			steps++;
		end
		v.is_keith = (last == TERM_W'(n));
		return v;
	endfunction

	function automatic logic [CAND_W-1:0] rand_candidate();
		int unsigned sel;
		int unsigned d;
		int unsigned lo;
		int unsigned hi;
		sel = $urandom_range(99);
		if (sel < 8)
			return CAND_W'(KEITH_SET[$urandom_range(N_KEITH-1)]);
		if (sel < 14)
			return CAND_W'($urandom);
		if (sel < 17)
			return CAND_W'($urandom_range(134217727, 100000000));
		if (sel < 19)
			return '0;
		d = $urandom_range(MAX_DIGITS, 1);
		lo = 1;
		for (int unsigned j = 1; j < d; j++)
			lo = lo * 10;
		hi = lo * 10 - 1;
		if (d == 1)
			lo = 1;
		return CAND_W'($urandom_range(hi, lo));
	endfunction

	// called at a rising edge; returns at the edge that accepts the transaction
	task automatic send_candidate(input logic [CAND_W-1:0] value, input keith_verdict_t verdict);
		while ($urandom_range(99) < send_idle_pct) begin
			cand_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cand_ch.valid <= 1'b1;
		cand_ch.candidate <= value;
		do
			@(posedge clk);
		while (!cand_ch.ready);
		pending_verdicts.push_back(verdict);
	endtask

	task automatic drain();
		cand_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic report(input string what, input keith_verdict_t want,
	                      input keith_verdict_t got);
		if (mismatch_count < MAX_SHOWN)
			$display("%0t: %s: expected is_keith=%0b digit_count=%0d, got is_keith=%0b digit_count=%0d",
			         $realtime, what, want.is_keith, want.digit_count,
			         got.is_keith, got.digit_count);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		keith_verdict_t got;
		keith_verdict_t want;
		res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.is_keith = res_ch.is_keith;
			got.digit_count = res_ch.digit_count;
			if (pending_verdicts.size() == 0) begin
				report("unexpected result", '0, got);
			end else begin
				want = pending_verdicts.pop_front();
				if (got.is_keith !== want.is_keith)
					report("is_keith mismatch", want, got);
				if (got.digit_count !== want.digit_count)
					report("digit_count mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_keith_number_test_unit: errors");
			$finish;
		end
	end

	initial begin
		keith_verdict_t verdict;
		mismatch_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cand_ch.valid = 1'b0;
		cand_ch.candidate = '0;
		res_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[r]) begin
			if (DIRECTED_ROWS[r].typed) begin
				verdict.is_keith = DIRECTED_ROWS[r].is_keith;
				verdict.digit_count = DIRECTED_ROWS[r].digit_count;
			end else begin
				verdict = keith_predict(DIRECTED_ROWS[r].value);
			end
			send_candidate(DIRECTED_ROWS[r].value, verdict);
		end
		drain();

		// flow-control phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 76 : (ph == 3) ? 22 : 0;
			recv_stall_pct = (ph == 2) ? 76 : (ph == 3) ? 22 : 0;
			for (int i = 0; i < RAND_PER_PH; i++) begin
				logic [CAND_W-1:0] value;
				value = rand_candidate();
				send_candidate(value, keith_predict(value));
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_verdicts.size() == 0)
			$display("tb_keith_number_test_unit: clean");
		else
			$display("tb_keith_number_test_unit: errors");
		$finish;
	end

endmodule

/* files.f */
design/knt_pkg.sv
design/knt_if.sv
design/keith_number_test_unit.sv
bench/tb_keith_number_test_unit.sv
